FILE: rtl/core/ude_pkg.sv
package ude_pkg;

  // Width of the running character count; output_length shows its low 16 bits.
  localparam int COUNT_BITS = 16;
  localparam int LenW       = 16;
  localparam int CountExtW  = (COUNT_BITS > LenW) ? COUNT_BITS : LenW;

  localparam int FifoDepth = 4;
  localparam int FifoAw    = $clog2(FifoDepth);

  localparam logic [7:0] CharUnderscore = 8'h5F;
  localparam logic [7:0] CharZero       = 8'h30;

  localparam logic [7:0] Ten     = 8'd10;
  localparam logic [7:0] Hundred = 8'd100;

  // One classified input byte as it waits in the queue.
  typedef struct packed {
    logic       esc;       // byte is written out as an escape sequence
    logic [7:0] raw;       // the byte itself, used when it passes through
    logic [1:0] nd_m1;     // number of decimal digits minus one
    logic [3:0] dig0;      // most significant digit
    logic [3:0] dig1;
    logic [3:0] dig2;
    logic       last;      // final byte of the string
  } item_t;

  function automatic logic is_alnum(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) ||
           (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A);
  endfunction

endpackage

FILE: rtl/core/ude_front.sv
module ude_front (
  input  logic [7:0]     byte_i,
  input  logic           last_i,
  output ude_pkg::item_t item_o
);
  import ude_pkg::*;

  logic [1:0]  hund;
  logic [6:0]  rem;
  logic [14:0] prod;
  logic [3:0]  tens;
  logic [3:0]  ones;

  always_comb begin
    if (byte_i >= 8'd200) begin
      hund = 2'd2;
    end else if (byte_i >= Hundred) begin
      hund = 2'd1;
    end else begin
      hund = 2'd0;
    end
    rem  = 7'(byte_i - 8'(hund) * Hundred);
    // Multiplying by 205/2048 gives the exact tens digit for values below 100.
    prod = 15'(rem) * 15'd205;
    tens = prod[14:11];
    ones = 4'(rem - 7'(tens) * 7'(Ten));
  end

  always_comb begin
    item_o.esc  = !is_alnum(byte_i);
    item_o.raw  = byte_i;
    item_o.last = last_i;
    item_o.dig2 = '0;
    if (byte_i < Ten) begin
      item_o.nd_m1 = 2'd0;
      item_o.dig0  = ones;
      item_o.dig1  = '0;
    end else if (byte_i < Hundred) begin
      item_o.nd_m1 = 2'd1;
      item_o.dig0  = tens;
      item_o.dig1  = ones;
    end else begin
      item_o.nd_m1 = 2'd2;
      item_o.dig0  = {2'b00, hund};
      item_o.dig1  = tens;
      item_o.dig2  = ones;
    end
  end

endmodule

FILE: rtl/core/ude_fifo.sv
module ude_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ude_pkg::item_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output ude_pkg::item_t head_o,
  output logic           empty_o
);
  import ude_pkg::*;

  item_t             mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoAw-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoAw:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (FifoAw + 1)'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (FifoAw + 1)'(do_push) - (FifoAw + 1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/core/ude_back.sv
module ude_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ude_pkg::item_t          head_i,
  input  logic                    empty_i,
  output logic                    pop_o,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic [7:0]              char_o,
  output logic                    run_last_o,
  output logic                    string_end_o,
  output logic [ude_pkg::LenW-1:0] length_o
);
  import ude_pkg::*;

  logic [1:0]            pos_q, pos_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  valid_q, valid_d;
  logic [7:0]            char_q, char_d;
  logic                  run_last_q, run_last_d;
  logic                  str_end_q, str_end_d;
  logic [COUNT_BITS-1:0] len_q, len_d;
  logic [CountExtW-1:0]  len_ext;

  logic                  load;
  logic [COUNT_BITS-1:0] count_inc;
  logic [3:0]            digit;
  logic                  is_end;

  assign load      = !empty_i && (!valid_q || ready_i);
  assign count_inc = (count_q == '1) ? count_q : count_q + 1'b1;

  always_comb begin
    unique case (pos_q)
      2'd1:    digit = head_i.dig0;
      2'd2:    digit = head_i.dig1;
      default: digit = head_i.dig2;
    endcase
    // Position zero of an escape is the underscore; the digits follow.
    if (!head_i.esc) begin
      is_end = 1'b1;
    end else begin
      is_end = (pos_q != 2'd0) && (pos_q - 2'd1 == head_i.nd_m1);
    end
  end

  always_comb begin
    pos_d      = pos_q;
    count_d    = count_q;
    valid_d    = valid_q && !ready_i;
    char_d     = char_q;
    run_last_d = run_last_q;
    str_end_d  = str_end_q;
    len_d      = len_q;
    pop_o      = 1'b0;
    if (load) begin
      valid_d    = 1'b1;
      run_last_d = is_end;
      str_end_d  = is_end && head_i.last;
      len_d      = count_inc;
      if (!head_i.esc) begin
        char_d = head_i.raw;
      end else if (pos_q == 2'd0) begin
        char_d = CharUnderscore;
      end else begin
        char_d = CharZero + 8'(digit);
      end
      if (is_end) begin
        pop_o   = 1'b1;
        pos_d   = 2'd0;
        count_d = head_i.last ? '0 : count_inc;
      end else begin
        pos_d   = pos_q + 2'd1;
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q     <= char_d;
    run_last_q <= run_last_d;
    str_end_q  <= str_end_d;
    len_q      <= len_d;
  end

  assign len_ext      = CountExtW'(len_q);
  assign valid_o      = valid_q;
  assign char_o       = char_q;
  assign run_last_o   = run_last_q;
  assign string_end_o = str_end_q;
  assign length_o     = len_ext[LenW-1:0];

endmodule

FILE: rtl/core/underscore_decimal_escaper.sv
// Escapes a byte string so that only letters, digits and underscores remain.
// Each byte transfer on the slave side yields a run of output transfers: a letter
// or digit passes as one character, any other byte becomes an underscore and its
// unsigned decimal value with no leading zeros, two to four characters in all.
// The emitter produces one character per cycle while the queue holds a byte and no
// character is held back by m_axis_tready; a four-entry queue between the
// classifier and the emitter lets new bytes be taken while a run is still going
// out. tlast marks the last character of each run, tuser the last character of
// the string, and tdata carries a saturating character count that restarts
// after the string's final byte.
module underscore_decimal_escaper (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // in_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] out_char, [23:8] output_length
  output logic        m_axis_tlast,   // run_last
  output logic        m_axis_tuser    // string_end
);
  import ude_pkg::*;

  item_t            front_item;
  item_t            head;
  logic             fifo_full;
  logic             fifo_empty;
  logic             pop;
  logic [7:0]       out_char;
  logic [LenW-1:0]  out_len;

  ude_front u_front (
    .byte_i (s_axis_tdata),
    .last_i (s_axis_tlast),
    .item_o (front_item)
  );

  ude_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid),
    .push_data_i (front_item),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (fifo_empty)
  );

  ude_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .empty_i      (fifo_empty),
    .pop_o        (pop),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .char_o       (out_char),
    .run_last_o   (m_axis_tlast),
    .string_end_o (m_axis_tuser),
    .length_o     (out_len)
  );

  assign s_axis_tready = !fifo_full;
  assign m_axis_tdata  = {out_len, out_char};

  // The end of a string is always the end of a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("string end flagged inside a run");

  // A character that does not close its run leaves its byte waiting in the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |-> !fifo_empty || !$past(rst_ni))
    else $error("run ended without its last character");

  // The emitter only consumes a byte whose run it is closing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> m_axis_tvalid && m_axis_tlast)
    else $error("queue entry dropped before its run closed");

  // A byte is taken only when the queue has room for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_full |-> !s_axis_tready)
    else $error("input accepted into a full queue");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ude_pkg::*;

  typedef struct packed {
    logic [7:0]  ch;
    logic        run_end;
    logic        str_end;
    logic [15:0] length;
  } esc_char_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  // Predicted characters, oldest first, and the predictor's own copy of the count.
  esc_char_t       pending_chars[$];
  longint unsigned run_count = 0;
  longint unsigned run_count_max = (64'd1 << COUNT_BITS) - 64'd1;

  bit src_idle_en = 1'b1;
  bit snk_idle_en = 1'b1;
  int sink_hold = 0;

  int error_count = 0;
  int bytes_sent = 0;
  int strings_sent = 0;
  int chars_checked = 0;
  int saturated_chars = 0;

  underscore_decimal_escaper u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] in_byte
    .s_axis_tlast  (s_axis_tlast),   // in_last
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] out_char, [23:8] output_length
    .m_axis_tlast  (m_axis_tlast),   // run_last
    .m_axis_tuser  (m_axis_tuser)    // string_end
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d characters outstanding", $time, pending_chars.size());
    $display("simulation failed");
    $finish;
  end

  function automatic bit is_word_char(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic void push_char(input logic [7:0] ch, input bit run_end,
                                    input bit str_end);
    esc_char_t c;
    if (run_count < run_count_max) run_count++;
    else saturated_chars++;
    c.ch      = ch;
    c.run_end = run_end;
    c.str_end = run_end && str_end;
    c.length  = run_count[15:0];
    pending_chars.push_back(c);
  endfunction

  function automatic void escape_byte(input logic [7:0] b, input bit last);
    logic [7:0] digits[3];
    int         nd;
    if (is_word_char(b)) begin
      push_char(b, 1'b1, last);
    end else begin
      if (b < 8'd10) begin
        digits[0] = b;
        nd = 1;
      end else if (b < 8'd100) begin
        digits[0] = b / 8'd10;
        digits[1] = b % 8'd10;
        nd = 2;
      end else begin
        digits[0] = b / 8'd100;
        digits[1] = (b / 8'd10) % 8'd10;
        digits[2] = b % 8'd10;
        nd = 3;
      end
      push_char(CharUnderscore, 1'b0, last);
      for (int i = 0; i < nd; i++) push_char(CharZero + digits[i], i == nd - 1, last);
    end
    if (last) run_count = 0;
  endfunction

  function automatic int pick_gap(input bit enabled, input int pct);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r >= pct) return 0;
    if (r < pct * 7 / 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit last);
    int gap;
    gap = pick_gap(src_idle_en, 40);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    escape_byte(b, last);
    bytes_sent++;
    if (last) strings_sent++;
  endtask

  task automatic release_source();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic report_field(input string name, input logic [15:0] exp_v,
                              input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      error_count++;
      if (error_count <= 40)
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
    end
  endtask

  // Checks each output transfer and drives tready with random stalls.
  always @(posedge clk_i) begin
    esc_char_t c;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_chars.size() == 0) begin
        error_count++;
        if (error_count <= 40)
          $display("%0t: unexpected character, expected none, got %h", $time, m_axis_tdata);
      end else begin
        c = pending_chars.pop_front();
        report_field("out_char", c.ch, m_axis_tdata[7:0]);
        report_field("run_last", c.run_end, m_axis_tlast);
        report_field("string_end", c.str_end, m_axis_tuser);
        report_field("output_length", c.length, m_axis_tdata[23:8]);
        chars_checked++;
      end
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      sink_hold = pick_gap(snk_idle_en, 30);
      m_axis_tready <= (sink_hold == 0);
      if (sink_hold > 0) sink_hold--;
    end
  end

  task automatic test_passthrough_edges();
    logic [7:0] edge_bytes[12] = '{8'h2F, "0", "9", 8'h3A, 8'h40, "A",
                                   "Z", 8'h5B, 8'h60, "a", "z", 8'h7B};
    foreach (edge_bytes[i]) send_byte(edge_bytes[i], i == 11);
  endtask

  task automatic test_escape_widths();
    logic [7:0] esc_bytes[9] = '{8'd0, 8'd9, 8'd10, 8'd99, 8'd100, 8'd127,
                                 8'd128, "_", 8'd255};
    foreach (esc_bytes[i]) send_byte(esc_bytes[i], i == 8);
  endtask

  task automatic test_single_byte_strings();
    send_byte("q", 1'b1);
    send_byte(8'h20, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_random_strings(input int n_items);
    int         sent;
    int         len;
    int         r;
    int         k;
    logic [7:0] b;
    logic [7:0] specials[8] = '{8'd0, 8'd9, 8'd10, 8'd99, 8'd100, 8'd255, "_", 8'd128};
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      // Some strings run with no idling on either side.
      src_idle_en = ($urandom_range(0, 4) != 0);
      snk_idle_en = ($urandom_range(0, 4) != 0);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          k = $urandom_range(0, 61);
          if (k < 10) b = "0" + k;
          else if (k < 36) b = "A" + (k - 10);
          else b = "a" + (k - 36);
        end else if (r < 50) begin
          b = specials[$urandom_range(0, 7)];
        end else begin
          b = $urandom_range(0, 255);
        end
        send_byte(b, i == len - 1);
        sent++;
      end
    end
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_passthrough_edges();
    test_escape_widths();
    test_single_byte_strings();
    test_random_strings(355);
    release_source();

    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d bytes in %0d strings; checked %0d characters.",
             bytes_sent, strings_sent, chars_checked);
    $display("Characters at the saturated count: %0d.", saturated_chars);
    if (error_count == 0 && pending_chars.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/ude_pkg.sv
rtl/core/ude_front.sv
rtl/core/ude_fifo.sv
rtl/core/ude_back.sv
rtl/core/underscore_decimal_escaper.sv
tb/testbench.sv
